### hdl/mts_pkg.sv
`default_nettype none

package mts_pkg;

    localparam int POS_BITS    = 16;
    localparam int SPAN_W      = 16;
    localparam int GRP_N       = 4;
    localparam int GRP_IDX_W   = $clog2(GRP_N);
    localparam int GRP_CNT_W   = $clog2(GRP_N + 1);
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);

    typedef logic [POS_BITS-1:0] t_pos;

    localparam t_pos POS_MAX = '1;

    localparam logic       OP_CHAR = 1'b0;
    localparam logic       OP_END  = 1'b1;

    localparam logic [1:0] TOK_MARK = 2'd0;
    localparam logic [1:0] TOK_SPAN = 2'd1;
    localparam logic [1:0] TOK_ERR  = 2'd2;

    localparam logic [2:0] ERR_NO_NAME   = 3'd0;
    localparam logic [2:0] ERR_NEED_SEP  = 3'd1;
    localparam logic [2:0] ERR_BAD_NAME  = 3'd2;
    localparam logic [2:0] ERR_NO_COLOR  = 3'd3;
    localparam logic [2:0] ERR_BAD_COLOR = 3'd4;
    localparam logic [2:0] ERR_NO_COLON  = 3'd5;
    localparam logic [2:0] ERR_TOO_LONG  = 3'd6;

    localparam logic [2:0] COLOR_DIGITS = 3'd6;

    localparam logic [7:0] CH_LT    = 8'h3c;
    localparam logic [7:0] CH_GT    = 8'h3e;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_LBRK  = 8'h5b;
    localparam logic [7:0] CH_RBRK  = 8'h5d;
    localparam logic [7:0] CH_LBRC  = 8'h7b;
    localparam logic [7:0] CH_RBRC  = 8'h7d;
    localparam logic [7:0] CH_BAR   = 8'h7c;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_CARET = 8'h5e;
    localparam logic [7:0] CH_DOLL  = 8'h24;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;

    typedef enum logic [3:0] {
        M_SKIP   = 4'd0,
        M_TOP    = 4'd1,
        M_TEXT   = 4'd2,
        M_BRACE  = 4'd3,
        M_ESC    = 4'd4,
        M_HSKIP1 = 4'd5,
        M_HNAME  = 4'd6,
        M_HSKIP2 = 4'd7,
        M_COLOR  = 4'd8,
        M_CBAD   = 4'd9,
        M_COLON  = 4'd10,
        M_ERR    = 4'd11
    } t_mode;

    typedef struct packed {
        logic       op;
        logic [7:0] ch;
    } t_in_word;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        mark_char;
        logic [SPAN_W-1:0] span_start;
        logic [SPAN_W-1:0] span_length;
        logic [2:0]        error_code;
        logic              last;
    } t_out_word;

    typedef t_out_word [GRP_N-1:0] t_grp;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic [SPAN_W-1:0] f_span(t_pos v);
        logic [31:0] w;
        w = 32'(v);
        return w[SPAN_W-1:0];
    endfunction

endpackage

`default_nettype wire

### hdl/mts_front.sv
`default_nettype none

module mts_front
    import mts_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_word i_in_word,
    input  wire t_qstat   i_qstat,
    output logic          o_push,
    output t_grp          o_grp
);

    t_mode            r_mode, n_mode;
    t_pos             r_pos, n_pos;
    t_pos             r_run_start, n_run_start;
    t_pos             r_run_trim, n_run_trim;
    t_pos             r_name_start, n_name_start;
    t_pos             r_name_end, n_name_end;
    logic             r_name_empty, n_name_empty;
    logic [2:0]       r_color_cnt, n_color_cnt;

    logic             acc, ch_acc, too_long, top_call;
    logic             c_sp, c_magic, c_hex, c_sep;
    logic [7:0]       c;
    t_pos             p;
    logic [2:0]       cc_inc;
    t_pos             hs_ns;
    t_mode            sep_mode;
    t_grp             toks;
    logic [GRP_CNT_W-1:0] cnt;
    logic [GRP_IDX_W-1:0] last_idx;

    function automatic t_out_word f_mark(logic [7:0] m);
        t_out_word t;
        t           = '0;
        t.kind      = TOK_MARK;
        t.mark_char = m;
        return t;
    endfunction

    function automatic t_out_word f_text(t_pos s, t_pos l);
        t_out_word t;
        t             = '0;
        t.kind        = TOK_SPAN;
        t.span_start  = f_span(s);
        t.span_length = f_span(l);
        return t;
    endfunction

    function automatic t_out_word f_err(logic [2:0] code, t_pos s, t_pos l);
        t_out_word t;
        t             = '0;
        t.kind        = TOK_ERR;
        t.span_start  = f_span(s);
        t.span_length = f_span(l);
        t.error_code  = code;
        return t;
    endfunction

    assign o_in_ready = !i_qstat.full;
    assign acc        = i_in_valid && o_in_ready;
    assign c          = i_in_word.ch;
    assign p          = r_pos;
    assign cc_inc     = r_color_cnt + 3'd1;
    assign too_long   = (r_pos == POS_MAX);
    assign ch_acc     = acc && (i_in_word.op == OP_CHAR) && (r_mode != M_ERR) && !too_long;

    assign c_sp    = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    assign c_magic = (c == CH_LT) || (c == CH_GT) || (c == CH_LPAR) || (c == CH_RPAR) ||
                     (c == CH_LBRK) || (c == CH_RBRK) || (c == CH_LBRC) || (c == CH_RBRC) ||
                     (c == CH_BAR) || (c == CH_BSL);
    assign c_hex   = ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66));
    assign c_sep   = (c == CH_BAR) || (c == CH_GT);

    assign sep_mode = (c == CH_BAR) ? M_SKIP : ((c == CH_GT) ? M_TOP : M_ERR);
    assign hs_ns    = (r_mode == M_HSKIP1) ? p : r_name_start;

    always_comb begin
        top_call = 1'b0;
        if (ch_acc) begin
            unique case (r_mode) inside
                M_SKIP:  top_call = !c_sp;
                M_TOP:   top_call = 1'b1;
                M_TEXT:  top_call = c_magic;
                M_BRACE: top_call = (c != CH_RBRC);
                default: top_call = 1'b0;
            endcase
        end
    end

    // next state
    always_comb begin
        n_mode       = r_mode;
        n_pos        = r_pos;
        n_run_start  = r_run_start;
        n_run_trim   = r_run_trim;
        n_name_start = r_name_start;
        n_name_end   = r_name_end;
        n_name_empty = r_name_empty;
        n_color_cnt  = r_color_cnt;
        if (acc && (i_in_word.op == OP_END)) begin
            n_mode       = M_SKIP;
            n_pos        = '0;
            n_run_start  = '0;
            n_run_trim   = '0;
            n_name_start = '0;
            n_name_end   = '0;
            n_name_empty = 1'b1;
            n_color_cnt  = '0;
        end else if (acc && (r_mode != M_ERR) && too_long) begin
            n_mode = M_ERR;
        end else if (ch_acc) begin
            n_pos = r_pos + t_pos'(1);
            unique case (r_mode) inside
                M_TEXT: begin
                    if (!c_magic && !c_sp) begin
                        n_run_trim = p + t_pos'(1);
                    end
                end
                M_BRACE: begin
                    if (c == CH_RBRC) begin
                        n_mode = M_TOP;
                    end
                end
                M_ESC: n_mode = M_TOP;
                M_HSKIP1: begin
                    if (!c_sp) begin
                        n_name_start = p;
                        if (c_magic) begin
                            n_name_end = p;
                            n_mode     = sep_mode;
                        end else begin
                            n_name_empty = 1'b0;
                            n_mode       = M_HNAME;
                        end
                    end
                end
                M_HNAME: begin
                    if (c_sp) begin
                        n_name_end = p;
                        n_mode     = M_HSKIP2;
                    end else if (c_magic) begin
                        n_name_end = p;
                        n_mode     = sep_mode;
                    end
                end
                M_HSKIP2: begin
                    if (!c_sp) begin
                        n_mode = sep_mode;
                    end
                end
                M_COLOR, M_CBAD: begin
                    n_color_cnt = cc_inc;
                    if (cc_inc >= COLOR_DIGITS) begin
                        n_mode = ((r_mode == M_COLOR) && c_hex) ? M_COLON : M_ERR;
                    end else if (!c_hex) begin
                        n_mode = M_CBAD;
                    end
                end
                M_COLON: n_mode = (c == CH_COLON) ? M_SKIP : M_ERR;
                default: ;
            endcase
            if (top_call) begin
                case (c) inside
                    CH_LT: begin
                        n_name_empty = 1'b1;
                        n_mode       = M_HSKIP1;
                    end
                    CH_LPAR, CH_LBRK: begin
                        n_color_cnt = '0;
                        n_mode      = M_COLOR;
                    end
                    CH_LBRC: n_mode = M_BRACE;
                    CH_GT, CH_RBRK, CH_RPAR, CH_RBRC: n_mode = M_TOP;
                    CH_BAR: n_mode = M_SKIP;
                    CH_BSL: n_mode = M_ESC;
                    default: begin
                        n_run_start = p;
                        n_run_trim  = c_sp ? p : p + t_pos'(1);
                        n_mode      = M_TEXT;
                    end
                endcase
            end
        end
    end

    // result words
    always_comb begin
        toks     = '0;
        cnt      = '0;
        last_idx = '0;
        if (acc && (i_in_word.op == OP_END)) begin
            unique case (r_mode) inside
                M_TEXT: begin
                    if (r_run_trim > r_run_start) begin
                        toks[cnt[GRP_IDX_W-1:0]] = f_text(r_run_start, r_run_trim - r_run_start);
                        cnt = cnt + GRP_CNT_W'(1);
                    end
                end
                M_BRACE: begin
                    toks[cnt[GRP_IDX_W-1:0]] = f_mark(CH_LBRC);
                    cnt = cnt + GRP_CNT_W'(1);
                    toks[cnt[GRP_IDX_W-1:0]] = f_mark(CH_CARET);
                    cnt = cnt + GRP_CNT_W'(1);
                end
                M_HSKIP1: begin
                    toks[cnt[GRP_IDX_W-1:0]] = f_mark(CH_CARET);
                    cnt = cnt + GRP_CNT_W'(1);
                    toks[cnt[GRP_IDX_W-1:0]] = f_mark(CH_DOLL);
                    cnt = cnt + GRP_CNT_W'(1);
                    toks[cnt[GRP_IDX_W-1:0]] = f_err(ERR_NO_NAME, p, '0);
                    cnt = cnt + GRP_CNT_W'(1);
                end
                M_HNAME: begin
                    toks[cnt[GRP_IDX_W-1:0]] = f_text(r_name_start, p - r_name_start);
                    cnt = cnt + GRP_CNT_W'(1);
                    toks[cnt[GRP_IDX_W-1:0]] = f_err(ERR_NEED_SEP, r_name_start,
                                                     p - r_name_start);
                    cnt = cnt + GRP_CNT_W'(1);
                end
                M_HSKIP2: begin
                    if (r_name_empty) begin
                        toks[cnt[GRP_IDX_W-1:0]] = f_err(ERR_NO_NAME, p, '0);
                    end else begin
                        toks[cnt[GRP_IDX_W-1:0]] = f_err(ERR_NEED_SEP, r_name_start,
                                                         r_name_end - r_name_start);
                    end
                    cnt = cnt + GRP_CNT_W'(1);
                end
                M_COLOR, M_CBAD: begin
                    if (r_color_cnt == '0) begin
                        toks[cnt[GRP_IDX_W-1:0]] = f_err(ERR_NO_COLOR, p, '0);
                    end else begin
                        toks[cnt[GRP_IDX_W-1:0]] = f_err(ERR_BAD_COLOR,
                                                         p - t_pos'(r_color_cnt),
                                                         t_pos'(r_color_cnt));
                    end
                    cnt = cnt + GRP_CNT_W'(1);
                end
                M_COLON: begin
                    toks[cnt[GRP_IDX_W-1:0]] = f_err(ERR_NO_COLON, p - t_pos'(6), t_pos'(6));
                    cnt = cnt + GRP_CNT_W'(1);
                end
                default: ;
            endcase
        end else if (acc && (r_mode != M_ERR) && too_long) begin
            toks[cnt[GRP_IDX_W-1:0]] = f_err(ERR_TOO_LONG, '0, r_pos);
            cnt = cnt + GRP_CNT_W'(1);
        end else if (ch_acc) begin
            unique case (r_mode) inside
                M_TEXT: begin
                    if (c_magic) begin
                        if (c_sep) begin
                            if (r_run_trim > r_run_start) begin
                                toks[cnt[GRP_IDX_W-1:0]] = f_text(r_run_start,
                                                                  r_run_trim - r_run_start);
                                cnt = cnt + GRP_CNT_W'(1);
                            end
                        end else begin
                            toks[cnt[GRP_IDX_W-1:0]] = f_text(r_run_start, p - r_run_start);
                            cnt = cnt + GRP_CNT_W'(1);
                        end
                    end
                end
                M_BRACE: begin
                    if (c != CH_RBRC) begin
                        toks[cnt[GRP_IDX_W-1:0]] = f_mark(CH_LBRC);
                        cnt = cnt + GRP_CNT_W'(1);
                        toks[cnt[GRP_IDX_W-1:0]] = f_mark(CH_CARET);
                        cnt = cnt + GRP_CNT_W'(1);
                    end
                end
                M_ESC: begin
                    toks[cnt[GRP_IDX_W-1:0]] = f_text(p, t_pos'(1));
                    cnt = cnt + GRP_CNT_W'(1);
                end
                M_HSKIP1, M_HNAME, M_HSKIP2: begin
                    if ((r_mode == M_HSKIP1) && !c_sp && c_magic) begin
                        toks[cnt[GRP_IDX_W-1:0]] = f_mark(CH_CARET);
                        cnt = cnt + GRP_CNT_W'(1);
                        toks[cnt[GRP_IDX_W-1:0]] = f_mark(CH_DOLL);
                        cnt = cnt + GRP_CNT_W'(1);
                    end
                    if ((r_mode == M_HNAME) && (c_sp || c_magic)) begin
                        toks[cnt[GRP_IDX_W-1:0]] = f_text(r_name_start, p - r_name_start);
                        cnt = cnt + GRP_CNT_W'(1);
                    end
                    if (((r_mode == M_HSKIP1) && !c_sp && c_magic) ||
                        ((r_mode == M_HNAME) && !c_sp && c_magic) ||
                        ((r_mode == M_HSKIP2) && !c_sp)) begin
                        if (c == CH_BAR) begin
                            toks[cnt[GRP_IDX_W-1:0]] = f_mark(CH_CARET);
                        end else if (c == CH_GT) begin
                            toks[cnt[GRP_IDX_W-1:0]] = f_mark(CH_GT);
                        end else begin
                            toks[cnt[GRP_IDX_W-1:0]] = f_err(ERR_BAD_NAME, hs_ns,
                                                             p + t_pos'(1) - hs_ns);
                        end
                        cnt = cnt + GRP_CNT_W'(1);
                    end
                end
                M_COLOR, M_CBAD: begin
                    if (cc_inc >= COLOR_DIGITS) begin
                        if ((r_mode == M_COLOR) && c_hex) begin
                            toks[cnt[GRP_IDX_W-1:0]] = f_text(p - t_pos'(5), t_pos'(6));
                        end else begin
                            toks[cnt[GRP_IDX_W-1:0]] = f_err(ERR_BAD_COLOR, p - t_pos'(5),
                                                             t_pos'(6));
                        end
                        cnt = cnt + GRP_CNT_W'(1);
                    end
                end
                M_COLON: begin
                    if (c == CH_COLON) begin
                        toks[cnt[GRP_IDX_W-1:0]] = f_mark(CH_CARET);
                    end else begin
                        toks[cnt[GRP_IDX_W-1:0]] = f_err(ERR_NO_COLON, p - t_pos'(6),
                                                         t_pos'(6));
                    end
                    cnt = cnt + GRP_CNT_W'(1);
                end
                default: ;
            endcase
            if (top_call) begin
                case (c) inside
                    CH_LT, CH_LPAR, CH_LBRK: begin
                        toks[cnt[GRP_IDX_W-1:0]] = f_mark(c);
                        cnt = cnt + GRP_CNT_W'(1);
                    end
                    CH_GT, CH_RBRK, CH_RPAR, CH_RBRC: begin
                        toks[cnt[GRP_IDX_W-1:0]] = f_mark(CH_DOLL);
                        cnt = cnt + GRP_CNT_W'(1);
                        toks[cnt[GRP_IDX_W-1:0]] = f_mark(c);
                        cnt = cnt + GRP_CNT_W'(1);
                    end
                    CH_BAR: begin
                        toks[cnt[GRP_IDX_W-1:0]] = f_mark(CH_DOLL);
                        cnt = cnt + GRP_CNT_W'(1);
                        toks[cnt[GRP_IDX_W-1:0]] = f_mark(CH_CARET);
                        cnt = cnt + GRP_CNT_W'(1);
                    end
                    default: ;
                endcase
            end
        end
        if (cnt != '0) begin
            last_idx = cnt[GRP_IDX_W-1:0] - GRP_IDX_W'(1);
            toks[last_idx].last = 1'b1;
        end
    end

    assign o_push = (cnt != '0);
    assign o_grp  = toks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= M_SKIP;
            r_pos        <= '0;
            r_run_start  <= '0;
            r_run_trim   <= '0;
            r_name_start <= '0;
            r_name_end   <= '0;
            r_name_empty <= 1'b1;
            r_color_cnt  <= '0;
        end else begin
            r_mode       <= n_mode;
            r_pos        <= n_pos;
            r_run_start  <= n_run_start;
            r_run_trim   <= n_run_trim;
            r_name_start <= n_name_start;
            r_name_end   <= n_name_end;
            r_name_empty <= n_name_empty;
            r_color_cnt  <= n_color_cnt;
        end
    end

endmodule

`default_nettype wire

### hdl/mts_queue.sv
`default_nettype none

module mts_queue
    import mts_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_grp i_grp,
    input  wire logic i_pop,
    output t_grp      o_head,
    output t_qstat    o_qstat
);

    t_grp              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QPTR_W:0]   r_level, n_level;

    assign o_head        = r_mem[r_rd];
    assign o_qstat.full  = (r_level == (QPTR_W + 1)'(QDEPTH));
    assign o_qstat.empty = (r_level == '0);

    always_comb begin
        n_wr    = i_push ? r_wr + QPTR_W'(1) : r_wr;
        n_rd    = i_pop ? r_rd + QPTR_W'(1) : r_rd;
        n_level = r_level + (QPTR_W + 1)'(i_push) - (QPTR_W + 1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_grp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_level <= n_level;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_qstat.full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_qstat.empty)
        else $error("queue pop while empty");

    a_level_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_level[QPTR_W-1:0] == QPTR_W'(r_wr - r_rd)) && (r_level <= (QPTR_W + 1)'(QDEPTH)))
        else $error("queue level out of step with pointers");

endmodule

`default_nettype wire

### hdl/mts_back.sv
`default_nettype none

module mts_back
    import mts_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_grp   i_head,
    input  wire t_qstat i_qstat,
    output logic        o_pop,
    output logic        o_out_valid,
    input  wire logic   i_out_ready,
    output t_out_word   o_out_word
);

    logic [GRP_IDX_W-1:0] r_idx, n_idx;
    t_out_word            cur;
    logic                 fire;

    assign cur         = i_head[r_idx];
    assign o_out_valid = !i_qstat.empty;
    assign o_out_word  = cur;
    assign fire        = o_out_valid && i_out_ready;
    assign o_pop       = fire && cur.last;

    always_comb begin
        n_idx = r_idx;
        if (fire) begin
            n_idx = cur.last ? '0 : r_idx + GRP_IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

endmodule

`default_nettype wire

### hdl/markup_token_scanner_unit.sv
// Results pass through a registered queue. Throughput: one input word per cycle unless the
// queue is full; the output side sends one word per cycle while i_out_ready is high, so an
// input that yields n words holds the drain side until all n words are taken.
// A four-entry queue of result groups sits between scanner and drain; input stalls when full.
// Reset: synchronous, active low; scanner mode, position and queue pointers are cleared.
`default_nettype none

module markup_token_scanner_unit
    import mts_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_word      o_out_word
);

    logic   push, pop;
    t_grp   grp, head;
    t_qstat qstat;

    mts_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .i_qstat    (qstat),
        .o_push     (push),
        .o_grp      (grp)
    );

    mts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_grp   (grp),
        .i_pop   (pop),
        .o_head  (head),
        .o_qstat (qstat)
    );

    mts_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_qstat     (qstat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire

### tb/tb_markup_token_scanner_unit.sv
`timescale 1ns / 100ps

module tb_markup_token_scanner_unit;
    import mts_pkg::*;

    localparam int WATCHDOG_LIMIT = 600;
    localparam int LIVE_TARGET    = 410;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      out_ready = 1'b0;
    t_in_word  in_word   = '0;
    logic      in_ready;
    logic      out_valid;
    t_out_word out_word;

    markup_token_scanner_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // scanner shadow state
    t_mode      sc_mode;
    t_pos       sc_pos;
    t_pos       run_beg;
    t_pos       run_keep_end;
    t_pos       nm_beg;
    t_pos       nm_end;
    logic       nm_none;
    logic [2:0] hex_cnt;

    t_out_word  step_tokens[$];
    t_out_word  pending_tokens[$];

    int         n_live     = 0;
    int         n_mismatch = 0;
    int         idle_cycles = 0;
    int         rdy_wait   = 0;
    int         rdy_draw;
    logic       idle_off   = 1'b0;

    function automatic logic is_blank(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_magic(logic [7:0] c);
        return c == CH_LT || c == CH_GT || c == CH_LPAR || c == CH_RPAR || c == CH_LBRK ||
               c == CH_RBRK || c == CH_LBRC || c == CH_RBRC || c == CH_BAR || c == CH_BSL;
    endfunction

    function automatic logic is_hexd(logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic void reset_scanner();
        sc_mode      = M_SKIP;
        sc_pos       = '0;
        run_beg      = '0;
        run_keep_end = '0;
        nm_beg       = '0;
        nm_end       = '0;
        nm_none      = 1'b1;
        hex_cnt      = '0;
    endfunction

    function automatic void put_token(logic [1:0] kind, logic [7:0] mk, logic [15:0] s,
                                      logic [15:0] l, logic [2:0] code);
        t_out_word tok;
        tok.kind        = kind;
        tok.mark_char   = mk;
        tok.span_start  = s;
        tok.span_length = l;
        tok.error_code  = code;
        tok.last        = 1'b0;
        if (step_tokens.size() < GRP_N) step_tokens.push_back(tok);
    endfunction

    function automatic void put_mark(logic [7:0] c);
        put_token(TOK_MARK, c, 16'd0, 16'd0, ERR_NO_NAME);
    endfunction

    function automatic void put_text(logic [15:0] s, logic [15:0] l);
        put_token(TOK_SPAN, 8'h00, s, l, ERR_NO_NAME);
    endfunction

    function automatic void raise_error(logic [2:0] code, logic [15:0] s, logic [15:0] l);
        put_token(TOK_ERR, 8'h00, s, l, code);
        sc_mode = M_ERR;
    endfunction

    function automatic void dispatch_top(logic [7:0] c, t_pos p);
        case (c)
            CH_LT: begin
                put_mark(c);
                nm_none = 1'b1;
                sc_mode = M_HSKIP1;
            end
            CH_LPAR, CH_LBRK: begin
                put_mark(c);
                hex_cnt = '0;
                sc_mode = M_COLOR;
            end
            CH_LBRC: sc_mode = M_BRACE;
            CH_GT, CH_RBRK, CH_RPAR, CH_RBRC: begin
                put_mark(CH_DOLL);
                put_mark(c);
                sc_mode = M_TOP;
            end
            CH_BAR: begin
                put_mark(CH_DOLL);
                put_mark(CH_CARET);
                sc_mode = M_SKIP;
            end
            CH_BSL: sc_mode = M_ESC;
            default: begin
                run_beg      = p;
                run_keep_end = is_blank(c) ? p : p + 16'd1;
                sc_mode      = M_TEXT;
            end
        endcase
    endfunction

    function automatic void header_sep(logic [7:0] c, t_pos p);
        if (c == CH_BAR) begin
            put_mark(CH_CARET);
            sc_mode = M_SKIP;
        end else if (c == CH_GT) begin
            put_mark(CH_GT);
            sc_mode = M_TOP;
        end else begin
            raise_error(ERR_BAD_NAME, nm_beg, p + 16'd1 - nm_beg);
        end
    endfunction

    function automatic void scan_char(logic [7:0] c, t_pos p);
        case (sc_mode)
            M_SKIP: if (!is_blank(c)) dispatch_top(c, p);
            M_TOP: dispatch_top(c, p);
            M_TEXT: begin
                if (is_magic(c)) begin
                    if (c == CH_BAR || c == CH_GT) begin
                        if (run_keep_end > run_beg) put_text(run_beg, run_keep_end - run_beg);
                    end else begin
                        put_text(run_beg, p - run_beg);
                    end
                    dispatch_top(c, p);
                end else if (!is_blank(c)) begin
                    run_keep_end = p + 16'd1;
                end
            end
            M_BRACE: begin
                if (c == CH_RBRC) begin
                    sc_mode = M_TOP;
                end else begin
                    put_mark(CH_LBRC);
                    put_mark(CH_CARET);
                    sc_mode = M_TOP;
                    dispatch_top(c, p);
                end
            end
            M_ESC: begin
                put_text(p, 16'd1);
                sc_mode = M_TOP;
            end
            M_HSKIP1: begin
                if (!is_blank(c)) begin
                    nm_beg = p;
                    if (is_magic(c)) begin
                        put_mark(CH_CARET);
                        put_mark(CH_DOLL);
                        nm_end = p;
                        header_sep(c, p);
                    end else begin
                        nm_none = 1'b0;
                        sc_mode = M_HNAME;
                    end
                end
            end
            M_HNAME: begin
                if (is_blank(c)) begin
                    put_text(nm_beg, p - nm_beg);
                    nm_end  = p;
                    sc_mode = M_HSKIP2;
                end else if (is_magic(c)) begin
                    put_text(nm_beg, p - nm_beg);
                    nm_end = p;
                    header_sep(c, p);
                end
            end
            M_HSKIP2: if (!is_blank(c)) header_sep(c, p);
            M_COLOR, M_CBAD: begin
                hex_cnt = hex_cnt + 3'd1;
                if (!is_hexd(c)) sc_mode = M_CBAD;
                if (hex_cnt >= COLOR_DIGITS) begin
                    if (sc_mode == M_COLOR) begin
                        put_text(p - 16'd5, 16'd6);
                        sc_mode = M_COLON;
                    end else begin
                        raise_error(ERR_BAD_COLOR, p - 16'd5, 16'd6);
                    end
                end
            end
            M_COLON: begin
                if (c == CH_COLON) begin
                    put_mark(CH_CARET);
                    sc_mode = M_SKIP;
                end else begin
                    raise_error(ERR_NO_COLON, p - 16'd6, 16'd6);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void flush_end(t_pos p);
        case (sc_mode)
            M_TEXT: if (run_keep_end > run_beg) put_text(run_beg, run_keep_end - run_beg);
            M_BRACE: begin
                put_mark(CH_LBRC);
                put_mark(CH_CARET);
            end
            M_HSKIP1: begin
                put_mark(CH_CARET);
                put_mark(CH_DOLL);
                raise_error(ERR_NO_NAME, p, 16'd0);
            end
            M_HNAME: begin
                put_text(nm_beg, p - nm_beg);
                raise_error(ERR_NEED_SEP, nm_beg, p - nm_beg);
            end
            M_HSKIP2: begin
                if (nm_none) raise_error(ERR_NO_NAME, p, 16'd0);
                else raise_error(ERR_NEED_SEP, nm_beg, nm_end - nm_beg);
            end
            M_COLOR, M_CBAD: begin
                if (hex_cnt == 3'd0) raise_error(ERR_NO_COLOR, p, 16'd0);
                else raise_error(ERR_BAD_COLOR, p - {13'd0, hex_cnt}, {13'd0, hex_cnt});
            end
            M_COLON: raise_error(ERR_NO_COLON, p - 16'd6, 16'd6);
            default: ;
        endcase
    endfunction

    function automatic void predict_word(t_in_word w);
        t_out_word tok;
        step_tokens.delete();
        if (w.op == OP_END) begin
            flush_end(sc_pos);
            reset_scanner();
        end else if (sc_mode != M_ERR) begin
            if (sc_pos >= POS_MAX) begin
                raise_error(ERR_TOO_LONG, 16'd0, sc_pos);
            end else begin
                scan_char(w.ch, sc_pos);
                sc_pos = sc_pos + 16'd1;
            end
        end
        for (int i = 0; i < step_tokens.size(); i++) begin
            tok      = step_tokens[i];
            tok.last = (i == step_tokens.size() - 1);
            pending_tokens.push_back(tok);
        end
    endfunction

    task automatic send_word(input logic op, input logic [7:0] ch);
        int gap;
        t_in_word w;
        gap  = idle_off ? 0 : $urandom_range(0, 14);
        w.op = op;
        w.ch = ch;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
        n_live++;
        predict_word(w);
    endtask

    task automatic send_chars(input string s);
        for (int i = 0; i < s.len(); i++) send_word(OP_CHAR, s[i]);
    endtask

    task automatic send_end();
        send_word(OP_END, 8'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_tokens.size() != 0) @(posedge clk);
    endtask

    function automatic logic [7:0] name_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (is_magic(b) || is_blank(b)) b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic logic [7:0] space_byte();
        int v;
        v = $urandom_range(8, 13);
        return (v == 8) ? CH_SPACE : 8'(v);
    endfunction

    function automatic logic [7:0] text_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 8'h61 + 8'($urandom_range(0, 25));
        if (r < 8) return space_byte();
        return name_byte();
    endfunction

    function automatic logic [7:0] hex_byte();
        int d;
        d = $urandom_range(0, 15);
        return (d < 10) ? 8'h30 + 8'(d) : 8'h61 + 8'(d - 10);
    endfunction

    task automatic send_random_fragment();
        int kind;
        int n;
        kind     = $urandom_range(0, 99);
        idle_off = ($urandom_range(0, 7) == 0);
        if (kind < 20) begin
            n = $urandom_range(1, 8);
            repeat (n) send_word(OP_CHAR, text_byte());
        end else if (kind < 40) begin
            send_word(OP_CHAR, CH_LT);
            repeat ($urandom_range(0, 2)) send_word(OP_CHAR, space_byte());
            repeat ($urandom_range(0, 5)) send_word(OP_CHAR, name_byte());
            repeat ($urandom_range(0, 2)) send_word(OP_CHAR, space_byte());
            n = $urandom_range(0, 9);
            if (n < 8) send_word(OP_CHAR, (n < 4) ? CH_BAR : CH_GT);
            else if (n == 8) send_word(OP_CHAR, 8'($urandom_range(0, 255)));
        end else if (kind < 55) begin
            send_word(OP_CHAR, ($urandom_range(0, 1) == 1) ? CH_LPAR : CH_LBRK);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : 6;
            repeat (n) begin
                if ($urandom_range(0, 11) == 0) send_word(OP_CHAR, 8'($urandom_range(0, 255)));
                else send_word(OP_CHAR, hex_byte());
            end
            if (n == 6) begin
                if ($urandom_range(0, 9) != 0) send_word(OP_CHAR, CH_COLON);
                else send_word(OP_CHAR, 8'($urandom_range(0, 255)));
            end
        end else if (kind < 65) begin
            send_word(OP_CHAR, CH_LBRC);
            if ($urandom_range(0, 1) == 1) send_word(OP_CHAR, CH_RBRC);
        end else if (kind < 75) begin
            case ($urandom_range(0, 4))
                0: send_word(OP_CHAR, CH_GT);
                1: send_word(OP_CHAR, CH_RBRK);
                2: send_word(OP_CHAR, CH_RPAR);
                3: send_word(OP_CHAR, CH_RBRC);
                default: send_word(OP_CHAR, CH_BAR);
            endcase
        end else if (kind < 83) begin
            send_word(OP_CHAR, CH_BSL);
            send_word(OP_CHAR, 8'($urandom_range(0, 255)));
        end else if (kind < 92) begin
            send_word(OP_CHAR, 8'($urandom_range(0, 255)));
        end else begin
            send_end();
        end
        // do not waste many words on a stopped scanner
        if (sc_mode == M_ERR && $urandom_range(0, 3) != 0) send_end();
    endtask

    task automatic test_directed();
        send_chars("\t <a");
        send_word(OP_CHAR, 8'hff);
        send_chars(">x \\");
        send_end();
        send_word(OP_CHAR, 8'h00);
        send_chars("[09af");
        send_end();
        send_chars("(0f9a3e:{>");
        send_end();
        send_chars("<ab");
        send_end();
    endtask

    task automatic test_random_stream();
        logic paused;
        paused = 1'b0;
        while (n_live < LIVE_TARGET) begin
            send_random_fragment();
            if (!paused && n_live >= 200) begin
                wait_drained();
                paused = 1'b1;
            end
        end
        idle_off = 1'b0;
        send_end();
    endtask

    task automatic check_token(input t_out_word got);
        t_out_word want;
        if (pending_tokens.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= 10) $display("unexpected word: %p", got);
        end else begin
            want = pending_tokens.pop_front();
            if (got.kind !== want.kind || got.mark_char !== want.mark_char ||
                got.span_start !== want.span_start || got.span_length !== want.span_length ||
                got.error_code !== want.error_code || got.last !== want.last) begin
                n_mismatch++;
                if (n_mismatch <= 10) begin
                    $display("mismatch: expected %p", want);
                    $display("          actual   %p", got);
                end
            end
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            rdy_wait  <= 0;
        end else if (out_valid && out_ready) begin
            check_token(out_word);
            rdy_draw = idle_off ? 0 : $urandom_range(0, 14);
            if (rdy_draw > 0) begin
                out_ready <= 1'b0;
                rdy_wait  <= rdy_draw - 1;
            end
        end else if (!out_ready) begin
            if (rdy_wait == 0) out_ready <= 1'b1;
            else rdy_wait <= rdy_wait - 1;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("markup_token_scanner_unit regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        reset_scanner();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_stream();
        in_valid <= 1'b0;
        for (int g = 0; g < 20000 && pending_tokens.size() != 0; g++) @(posedge clk);
        repeat (8) @(posedge clk);
        if (n_mismatch == 0 && pending_tokens.size() == 0) begin
            $display("markup_token_scanner_unit regression: pass");
        end else begin
            $display("markup_token_scanner_unit regression: fail");
        end
        $finish;
    end

endmodule
